### rtl/kinematic_covariance_matrix_defines.svh
`ifndef KINEMATIC_COVARIANCE_MATRIX_DEFINES_SVH
`define KINEMATIC_COVARIANCE_MATRIX_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define KCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define KCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/kcm_pkg.sv
`timescale 1ns / 1ps
package kcm_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int NFEAT   = 6;
    localparam int NPAIR   = 21;
    localparam int NSLOT   = NFEAT + NPAIR;
    localparam int SLOT_AW = 5;
    localparam int IDX_W   = 3;
    localparam int IN_W    = 16;
    localparam int COV_W   = 48;
    localparam int DIG_W   = 16;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FEW  = 2'd1;
    localparam logic [1:0] STAT_DROP = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NFEAT - 1);

    // Feature pair of each cross-sum slot
    localparam logic [IDX_W-1:0] PAIR_ROW [NPAIR] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5};
    localparam logic [IDX_W-1:0] PAIR_COL [NPAIR] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5};

    // Cross-sum slot of each matrix entry
    localparam logic [SLOT_AW-1:0] PAIR_SLOT [NFEAT][NFEAT] = '{
        '{5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5},
        '{5'd1,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10},
        '{5'd2,  5'd7,  5'd11, 5'd12, 5'd13, 5'd14},
        '{5'd3,  5'd8,  5'd12, 5'd15, 5'd16, 5'd17},
        '{5'd4,  5'd9,  5'd13, 5'd16, 5'd18, 5'd19},
        '{5'd5,  5'd10, 5'd14, 5'd17, 5'd19, 5'd20}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_ACC_END,
        ST_ENTRY,
        ST_RD_I,
        ST_RD_J,
        ST_RD_P,
        ST_LOAD,
        ST_MUL,
        ST_MUL_WAIT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

endpackage

### rtl/kinematic_covariance_matrix.sv
`timescale 1ns / 1ps
// A sample that forms a feature vector is accepted, then makes 27 read-modify-write
// passes through the sum memory and one write-back; o_stall holds off the next sample.
// A final sample then emits 36 words, each after three memory reads, the multipliers
// and the 48-step divider (directly with too few samples), held under output stalls.
// Reset is synchronous and active low; the sum memory reads as zero through
// per-entry valid bits, so no clearing pass follows reset or a final sample.
module kinematic_covariance_matrix #(
    parameter int MAX_SAMPLES = kcm_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = kcm_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = kcm_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [kcm_pkg::IN_W-1:0]   i_x_sample,
    input  logic signed [kcm_pkg::IN_W-1:0]   i_y_sample,
    input  logic                              i_final_sample,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [kcm_pkg::IDX_W-1:0]         o_row_index,
    output logic [kcm_pkg::IDX_W-1:0]         o_col_index,
    output logic signed [kcm_pkg::COV_W-1:0]  o_cov_value,
    output logic [1:0]                        o_status,
    output logic                              o_last_entry
);
    import kcm_pkg::*;

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int FW  = SAMPLE_BITS + 3;
    localparam int SW  = (FW + CW > 64) ? 64 : FW + CW;
    localparam int PW  = (2 * FW - 1 + CW > 64) ? 64 : 2 * FW - 1 + CW;
    localparam int MW  = CW + 1;
    localparam int NW  = ((PW + MW > 2 * SW) ? PW + MW : 2 * SW) + 1;
    localparam int DW  = 2 * CW;

    t_state r_state, n_state;

    logic                      in_acc;
    logic                      cap_full;
    logic                      cnt_ge2;
    logic                      few;
    logic                      last;
    logic                      mul_start;
    logic                      div_start;
    logic [SAMPLE_BITS-1:0]    x_raw, y_raw;
    logic signed [FW-1:0]      x_f, y_f;
    logic [CW-1:0]             m_cnt;

    logic signed [FW-1:0]      r_px1, r_px2, r_py1, r_py2;
    logic signed [FW-1:0]      r_f [NFEAT];
    logic [CW-1:0]             r_count;
    logic                      r_ovf;
    logic                      r_fin;
    logic [SLOT_AW-1:0]        r_k;
    logic [IDX_W-1:0]          r_i, r_j;

    // Sum memory and its read-modify-write pipe
    logic signed [PW-1:0]      mem [NSLOT];
    logic [NSLOT-1:0]          r_vld;
    logic [SLOT_AW-1:0]        rd_addr;
    logic signed [PW-1:0]      r_rdata;
    logic                      r_rvld;
    logic signed [PW-1:0]      rd_eff;
    logic [SLOT_AW-1:0]        pidx;
    logic signed [2*FW-1:0]    fprod;
    logic signed [PW-1:0]      addend;
    logic signed [PW-1:0]      r_add;
    logic [SLOT_AW-1:0]        r_wa;
    logic                      r_wv;
    logic signed [PW-1:0]      wr_data;

    // Covariance datapath
    logic signed [SW-1:0]      r_si, r_sj;
    logic signed [PW-1:0]      r_sp;
    logic signed [MW-1:0]      r_m;
    logic [DW-1:0]             r_den;
    logic signed [NW-1:0]      r_num;
    logic signed [PW+MW-1:0]   p_cross;
    logic signed [2*SW-1:0]    p_mean;
    logic                      mp_done, ms_done, dv_done;
    logic signed [COV_W-1:0]   dv_q;
    logic signed [COV_W-1:0]   r_cov;
    logic                      r_ovalid;

    // Sign-extend the used low bits of each sample
    assign x_raw = SAMPLE_BITS'({8'd0, i_x_sample});
    assign y_raw = SAMPLE_BITS'({8'd0, i_y_sample});
    assign x_f   = FW'(signed'(x_raw));
    assign y_f   = FW'(signed'(y_raw));

    assign in_acc   = i_valid && (r_state == ST_IDLE);
    assign cap_full = r_count >= CW'(MAX_SAMPLES);
    assign cnt_ge2  = r_count >= CW'(2);
    assign few      = r_count < CW'(3);
    assign last     = (r_i == LAST_IDX) && (r_j == LAST_IDX);
    assign m_cnt    = r_count - CW'(2);

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the sequencer
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (cap_full || !cnt_ge2) begin
                        n_state = i_final_sample ? ST_ENTRY : ST_IDLE;
                    end else begin
                        n_state = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                if (r_k == SLOT_AW'(NSLOT - 1)) n_state = ST_ACC_END;
            end
            ST_ACC_END:  n_state = r_fin ? ST_ENTRY : ST_IDLE;
            ST_ENTRY:    n_state = few ? ST_OUT : ST_RD_I;
            ST_RD_I:     n_state = ST_RD_J;
            ST_RD_J:     n_state = ST_RD_P;
            ST_RD_P:     n_state = ST_LOAD;
            ST_LOAD:     n_state = ST_MUL;
            ST_MUL: begin
                mul_start = 1'b1;
                n_state   = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mp_done && ms_done) n_state = ST_DIV;
            end
            ST_DIV: begin
                div_start = 1'b1;
                n_state   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (dv_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) n_state = last ? ST_IDLE : ST_ENTRY;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Select the memory read address
    always_comb begin
        case (r_state)
            ST_ACC:  rd_addr = r_k;
            ST_RD_I: rd_addr = SLOT_AW'(r_i);
            ST_RD_J: rd_addr = SLOT_AW'(r_j);
            ST_RD_P: rd_addr = SLOT_AW'(NFEAT) + PAIR_SLOT[r_i][r_j];
            default: rd_addr = '0;
        endcase
    end

    // Form the addend for slot r_k: a feature or a feature product
    assign pidx   = (r_k >= SLOT_AW'(NFEAT)) ? (r_k - SLOT_AW'(NFEAT)) : '0;
    assign fprod  = r_f[PAIR_ROW[pidx]] * r_f[PAIR_COL[pidx]];
    assign addend = (r_k < SLOT_AW'(NFEAT)) ? PW'(r_f[r_k[IDX_W-1:0]]) : PW'(fprod);

    assign rd_eff  = r_rvld ? r_rdata : '0;
    assign wr_data = rd_eff + r_add;

    // Read and write the sum memory
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
        if (r_wv) begin
            mem[r_wa] <= wr_data;
        end
    end

    // Update control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_fin    <= 1'b0;
            r_k      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_vld    <= '0;
            r_rvld   <= 1'b0;
            r_wv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rvld <= r_vld[rd_addr];
            r_wv   <= (r_state == ST_ACC);
            if (r_wv) begin
                r_vld[r_wa] <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_fin <= i_final_sample;
                        r_k   <= '0;
                        if (cap_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                ST_ACC: begin
                    r_k <= r_k + SLOT_AW'(1);
                end
                ST_ENTRY: begin
                    if (few) r_ovalid <= 1'b1;
                end
                ST_DIV_WAIT: begin
                    if (dv_done) r_ovalid <= 1'b1;
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        if (last) begin
                            // Drop the count, overflow flag, sums and indices once the matrix is out
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_vld   <= '0;
                            r_i     <= '0;
                            r_j     <= '0;
                        end else if (r_j == LAST_IDX) begin
                            r_j <= '0;
                            r_i <= r_i + IDX_W'(1);
                        end else begin
                            r_j <= r_j + IDX_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        r_add <= addend;
        r_wa  <= r_k;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && !cap_full) begin
                    r_px2 <= r_px1;
                    r_px1 <= x_f;
                    r_py2 <= r_py1;
                    r_py1 <= y_f;
                    r_f[0] <= x_f;
                    r_f[1] <= y_f;
                    r_f[2] <= x_f - r_px1;
                    r_f[3] <= y_f - r_py1;
                    r_f[4] <= x_f - (r_px1 + r_px1) + r_px2;
                    r_f[5] <= y_f - (r_py1 + r_py1) + r_py2;
                end
            end
            ST_ENTRY: begin
                r_m   <= signed'({1'b0, m_cnt});
                r_den <= DW'(m_cnt * m_cnt);
                if (few) r_cov <= '0;
            end
            ST_RD_J:     r_si  <= rd_eff[SW-1:0];
            ST_RD_P:     r_sj  <= rd_eff[SW-1:0];
            ST_LOAD:     r_sp  <= rd_eff;
            ST_MUL_WAIT: r_num <= NW'(p_cross) - NW'(p_mean);
            ST_DIV_WAIT: r_cov <= dv_q;
            default: ;
        endcase
    end

    kcm_mul #(
        .AW (PW),
        .BW (MW)
    ) u_mul_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_sp),
        .i_b     (r_m),
        .o_prod  (p_cross),
        .o_done  (mp_done)
    );

    kcm_mul #(
        .AW (SW),
        .BW (SW)
    ) u_mul_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_si),
        .i_b     (r_sj),
        .o_prod  (p_mean),
        .o_done  (ms_done)
    );

    kcm_div #(
        .NW        (NW),
        .DW        (DW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_q     (dv_q),
        .o_done  (dv_done)
    );

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_ovalid;
    assign o_row_index  = r_i;
    assign o_col_index  = r_j;
    assign o_cov_value  = r_cov;
    assign o_status     = few ? STAT_FEW : (r_ovf ? STAT_DROP : STAT_OK);
    assign o_last_entry = last;

endmodule

### rtl/kcm_mul.sv
`timescale 1ns / 1ps
module kcm_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [AW-1:0]   i_a,
    input  logic signed [BW-1:0]   i_b,
    output logic signed [AW+BW-1:0] o_prod,
    output logic                   o_done
);
    import kcm_pkg::*;

    localparam int PW    = AW + BW;
    localparam int NSTEP = (BW + DIG_W - 1) / DIG_W;
    localparam int UBW   = NSTEP * DIG_W;
    localparam int CNT_W = $clog2(NSTEP + 1);

    logic [AW-1:0]       a_mag;
    logic [BW-1:0]       b_mag;
    logic [PW+DIG_W-1:0] step_prod;
    logic [PW-1:0]       r_ua;
    logic [UBW-1:0]      r_ub;
    logic [PW-1:0]       r_acc;
    logic                r_neg;
    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;

    // Take magnitudes, multiply one digit of b per cycle
    assign a_mag     = i_a[AW-1] ? (~i_a + AW'(1)) : i_a;
    assign b_mag     = i_b[BW-1] ? (~i_b + BW'(1)) : i_b;
    assign step_prod = r_ua * r_ub[DIG_W-1:0];

    // Sequence the digit steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NSTEP - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Shift operands and accumulate partial products
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= PW'(a_mag);
            r_ub  <= UBW'(b_mag);
            r_acc <= '0;
            r_neg <= i_a[AW-1] ^ i_b[BW-1];
        end else if (r_busy) begin
            r_ua  <= r_ua << DIG_W;
            r_ub  <= r_ub >> DIG_W;
            r_acc <= r_acc + step_prod[PW-1:0];
        end
    end

    assign o_prod = r_neg ? (~r_acc + PW'(1)) : r_acc;
    assign o_done = r_done;

endmodule

### rtl/kcm_div.sv
`timescale 1ns / 1ps
module kcm_div #(
    parameter int NW        = 64,
    parameter int DW        = 26,
    parameter int FRAC_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [NW-1:0]        i_num,
    input  logic [DW-1:0]               i_den,
    output logic signed [kcm_pkg::COV_W-1:0] o_q,
    output logic                        o_done
);
    import kcm_pkg::*;

    localparam int QW    = COV_W;
    localparam int SH    = COV_W - FRAC_BITS;
    localparam int LW0   = (NW > DW) ? NW : DW;
    localparam int LW    = (LW0 > QW) ? LW0 : QW;
    localparam int CNT_W = $clog2(QW + 1);

    logic [NW-1:0]    mag;
    logic [LW-1:0]    mag_l;
    logic [LW-1:0]    mag_hi;
    logic [DW:0]      trial;
    logic             fits;
    logic [QW:0]      q_mag;
    logic [QW:0]      q_pos;
    logic [QW:0]      q_neg;
    logic [QW:0]      q_neg_n;
    logic [DW-1:0]    r_den;
    logic [DW-1:0]    r_rem;
    logic [QW-1:0]    r_dvd;
    logic [QW-1:0]    r_q;
    logic             r_neg;
    logic             r_sat;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;

    // Split the scaled magnitude into the leading remainder and the bits to shift in
    assign mag    = i_num[NW-1] ? (~i_num + NW'(1)) : i_num;
    assign mag_l  = LW'(mag);
    assign mag_hi = mag_l >> SH;

    // One restoring step per cycle
    assign trial = {r_rem, r_dvd[QW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(QW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_neg <= i_num[NW-1];
            r_sat <= mag_hi >= LW'(i_den);
            r_rem <= DW'(mag_hi);
            r_dvd <= QW'(mag_l << FRAC_BITS);
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(trial - {1'b0, r_den}) : DW'(trial);
            r_dvd <= r_dvd << 1;
            r_q   <= {r_q[QW-2:0], fits};
        end
    end

    // Clamp to the signed output range
    assign q_mag   = r_sat ? ((QW+1)'(1) << QW) : {1'b0, r_q};
    assign q_pos   = (q_mag > (((QW+1)'(1) << (QW-1)) - (QW+1)'(1)))
                   ? (((QW+1)'(1) << (QW-1)) - (QW+1)'(1)) : q_mag;
    assign q_neg   = (q_mag > ((QW+1)'(1) << (QW-1))) ? ((QW+1)'(1) << (QW-1)) : q_mag;
    assign q_neg_n = ~q_neg + (QW+1)'(1);
    assign o_q     = r_neg ? q_neg_n[QW-1:0] : q_pos[QW-1:0];
    assign o_done  = r_done;

endmodule

### rtl/kcm_chk.sv
`timescale 1ns / 1ps
`include "kinematic_covariance_matrix_defines.svh"
module kcm_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [kcm_pkg::IDX_W-1:0]         o_row_index,
    input logic [kcm_pkg::IDX_W-1:0]         o_col_index,
    input logic signed [kcm_pkg::COV_W-1:0]  o_cov_value,
    input logic [1:0]                        o_status,
    input logic                              o_last_entry
);
    import kcm_pkg::*;

    // A stalled word holds
    `KCM_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_cov_value) && $stable(o_row_index) && $stable(o_col_index), "output word changed under stall")

    // Input is held off while a word is out
    `KCM_ASSERT_NOW(a_busy_out, o_valid, o_stall, "input open while output word pending")

    // The last word closes the matrix
    `KCM_ASSERT_NOW(a_last_pos, o_valid && o_last_entry, (o_row_index == LAST_IDX) && (o_col_index == LAST_IDX), "last flag off the final entry")

    // Too few samples gives zeros
    `KCM_ASSERT_NOW(a_few_zero, o_valid && (o_status == STAT_FEW), o_cov_value == '0, "nonzero entry with too few samples")

endmodule

bind kinematic_covariance_matrix kcm_chk u_kcm_chk (.*);
